// ----- design/stip_pkg.sv -----
// Shared types, constants and parse state for the string-to-integer parser.
`default_nettype none
package stip_pkg;

  localparam int VALUE_BITS    = 64;
  localparam int POSITION_BITS = 16;
  localparam int RADIX_BITS    = 6;
  localparam int CHAR_BITS     = 8;
  localparam int OUT_VAL_BITS  = 64;
  localparam int OUT_POS_BITS  = 16;
  localparam int DIGIT_BITS    = 7;
  localparam int PROD_BITS     = VALUE_BITS + RADIX_BITS;
  localparam int OUT_DATA_BITS = 88;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
  localparam logic [RADIX_BITS-1:0] RADIX_AUTO  = RADIX_BITS'(0);
  localparam logic [RADIX_BITS-1:0] RADIX_ONE   = RADIX_BITS'(1);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
  localparam logic [RADIX_BITS-1:0] BASE_DEC    = RADIX_BITS'(10);
  localparam logic [RADIX_BITS-1:0] BASE_OCT    = RADIX_BITS'(8);
  localparam logic [RADIX_BITS-1:0] BASE_HEX    = RADIX_BITS'(16);

  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_LO_Z  = 8'h7A;

  localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = DIGIT_BITS'(99);

  localparam logic [VALUE_BITS-1:0]    VALUE_LIM = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;

  typedef enum logic [1:0] {
    PH_WS,
    PH_SIGNED,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BASE,
    ST_CHAR,
    ST_OVF
  } status_t;

  typedef struct packed {
    phase_t                   phase;
    logic                     neg;
    logic                     lzero;
    logic [RADIX_BITS-1:0]    base;
    logic [VALUE_BITS-1:0]    acc;
    logic [POSITION_BITS-1:0] pos;
    logic [POSITION_BITS-1:0] stop;
    status_t                  err;
  } parse_state_t;

  typedef struct packed {
    status_t                 status;
    logic [OUT_POS_BITS-1:0] stop_position;
    logic [OUT_VAL_BITS-1:0] value;
  } result_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase: PH_WS,
    neg:   1'b0,
    lzero: 1'b0,
    base:  '0,
    acc:   '0,
    pos:   '0,
    stop:  '0,
    err:   ST_OK
  };

endpackage
`default_nettype wire

// ----- design/stip_step.sv -----
// Per-character parse step: next parse state and the result for a final character.
`default_nettype none
module stip_step (
  input  wire logic [stip_pkg::RADIX_BITS-1:0] radix,
  input  wire logic [stip_pkg::CHAR_BITS-1:0]  char_code,
  input  wire logic                            last_char,
  input  wire stip_pkg::parse_state_t          cur,
  output stip_pkg::parse_state_t               nxt,
  output stip_pkg::result_t                    res
);

  function automatic logic is_space(input logic [stip_pkg::CHAR_BITS-1:0] c);
    is_space = (c == stip_pkg::CH_SPACE) || (c >= stip_pkg::CH_TAB && c <= stip_pkg::CH_CR);
  endfunction

  function automatic logic [stip_pkg::DIGIT_BITS-1:0] digit_val(
    input logic [stip_pkg::CHAR_BITS-1:0] c
  );
    logic [stip_pkg::CHAR_BITS-1:0] t;
    t = '0;
    if (c >= stip_pkg::CH_ZERO && c <= stip_pkg::CH_NINE) begin
      t = c - stip_pkg::CH_ZERO;
    end else if (c >= stip_pkg::CH_UP_A && c <= stip_pkg::CH_UP_Z) begin
      t = c - stip_pkg::CH_UP_A + 8'd10;
    end else if (c >= stip_pkg::CH_LO_A && c <= stip_pkg::CH_LO_Z) begin
      t = c - stip_pkg::CH_LO_A + 8'd10;
    end else begin
      t = 8'(stip_pkg::DIGIT_NONE);
    end
    digit_val = t[stip_pkg::DIGIT_BITS-1:0];
  endfunction

  stip_pkg::parse_state_t                s;
  logic                                  take;
  logic                                  begin_num;
  logic                                  base_bad;
  logic                                  end_char;
  logic [stip_pkg::POSITION_BITS-1:0]    pn;
  logic [stip_pkg::DIGIT_BITS-1:0]       digit;
  logic [stip_pkg::PROD_BITS-1:0]        prod;
  logic [stip_pkg::VALUE_BITS-1:0]       v;
  logic [31:0]                           stop_w;

  always_comb begin
    s         = cur;
    take      = 1'b0;
    begin_num = 1'b0;
    base_bad  = (radix == stip_pkg::RADIX_ONE) || (radix > stip_pkg::RADIX_MAX);
    end_char  = (char_code == stip_pkg::CH_NUL) || is_space(char_code);
    pn        = (cur.pos == stip_pkg::POS_MAX) ? cur.pos : cur.pos + 1'b1;

    case (cur.phase)
      stip_pkg::PH_WS: begin
        if (!is_space(char_code)) begin
          if (char_code == stip_pkg::CH_PLUS || char_code == stip_pkg::CH_MINUS) begin
            s.neg   = (char_code == stip_pkg::CH_MINUS);
            s.phase = stip_pkg::PH_SIGNED;
          end else begin
            begin_num = 1'b1;
          end
        end
      end
      stip_pkg::PH_SIGNED: begin
        begin_num = 1'b1;
      end
      stip_pkg::PH_DIGITS: begin
        s.lzero = 1'b0;
        if (cur.lzero &&
            (char_code == stip_pkg::CH_LO_X || char_code == stip_pkg::CH_UP_X)) begin
          s.base = stip_pkg::BASE_HEX;
        end else if (end_char) begin
          s.stop  = cur.pos;
          s.phase = stip_pkg::PH_DONE;
        end else begin
          take = 1'b1;
        end
      end
      default: ;
    endcase

    if (begin_num) begin
      if (base_bad) begin
        s.stop  = cur.pos;
        s.err   = stip_pkg::ST_BASE;
        s.phase = stip_pkg::PH_DONE;
      end else begin
        s.phase = stip_pkg::PH_DIGITS;
        if (end_char) begin
          s.base  = (radix == stip_pkg::RADIX_AUTO) ? stip_pkg::BASE_DEC : radix;
          s.stop  = cur.pos;
          s.phase = stip_pkg::PH_DONE;
        end else if (radix == stip_pkg::RADIX_AUTO) begin
          if (char_code == stip_pkg::CH_ZERO) begin
            s.base  = stip_pkg::BASE_OCT;
            s.lzero = 1'b1;
          end else begin
            s.base = stip_pkg::BASE_DEC;
            take   = 1'b1;
          end
        end else begin
          s.base = radix;
          if (radix == stip_pkg::BASE_HEX && char_code == stip_pkg::CH_ZERO) begin
            s.lzero = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
      end
    end

    // acc * base + d > lim is the same test as acc > (lim - d) / base
    digit = digit_val(char_code);
    prod  = stip_pkg::PROD_BITS'(s.acc) * stip_pkg::PROD_BITS'(s.base)
          + stip_pkg::PROD_BITS'(digit);
    if (take) begin
      if (digit >= stip_pkg::DIGIT_BITS'(s.base)) begin
        s.stop  = cur.pos;
        s.err   = stip_pkg::ST_CHAR;
        s.phase = stip_pkg::PH_DONE;
      end else begin
        if (s.err != stip_pkg::ST_OVF &&
            prod > stip_pkg::PROD_BITS'(stip_pkg::VALUE_LIM)) begin
          s.err = stip_pkg::ST_OVF;
        end
        s.acc = prod[stip_pkg::VALUE_BITS-1:0];
      end
    end

    // string ended without a terminator: act as if a NUL followed
    if (last_char) begin
      if (s.phase == stip_pkg::PH_WS || s.phase == stip_pkg::PH_SIGNED) begin
        s.stop  = pn;
        s.phase = stip_pkg::PH_DONE;
        if (base_bad) begin
          s.err = stip_pkg::ST_BASE;
        end
      end else if (s.phase != stip_pkg::PH_DONE) begin
        s.stop  = pn;
        s.phase = stip_pkg::PH_DONE;
      end
    end

    if (s.err == stip_pkg::ST_BASE || s.err == stip_pkg::ST_CHAR) begin
      v = '1;
    end else begin
      v = s.neg ? (~s.acc + 1'b1) : s.acc;
    end
    stop_w = 32'(s.stop);

    res.value         = stip_pkg::OUT_VAL_BITS'($signed(v));
    res.stop_position = (stop_w > 32'(16'hFFFF)) ? 16'hFFFF
                                                 : stop_w[stip_pkg::OUT_POS_BITS-1:0];
    res.status        = s.err;

    if (last_char) begin
      nxt = stip_pkg::STATE_CLEAR;
    end else begin
      nxt     = s;
      nxt.pos = pn;
    end
  end

endmodule
`default_nettype wire

// ----- design/string_to_integer_parser_unit.sv -----
// Streaming strtol-style parser: one character per beat in, one result per string out.
//
// Input channel in_*: one character per beat in in_tdata[7:0], in_tlast on the
// final character of a string. Result channel out_*: one beat per string, sent
// for the beat that carried in_tlast. cfg_we/cfg_wdata write the radix
// (0 = auto, 2..36 valid, others flagged as a bad base); write it only while idle.
//
// Throughput: one character per cycle while the result channel is not
// stalled. The parse state is updated per character by a single 64x6
// multiply-add and compare. A final character passes the input register,
// then the result register, before it shows on out_tvalid.
//
// Reset (rst_n low, synchronous) empties both registers, clears the parse
// state and sets the radix to 10. When out_tready is low the result beat
// holds; the input register still takes one more character, after which
// in_tready drops until the result is taken. Characters after a stop are
// consumed and ignored up to the final one.
`default_nettype none
module string_to_integer_parser_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [stip_pkg::RADIX_BITS-1:0]      cfg_wdata,     // radix
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [stip_pkg::CHAR_BITS-1:0]       in_tdata,      // char_code
  input  wire logic                                 in_tlast,      // last_char
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // value[63:0], stop_position[79:64], status[81:80], zeros[87:82]
  output logic [stip_pkg::OUT_DATA_BITS-1:0]        out_tdata
);

  logic [stip_pkg::RADIX_BITS-1:0]  radix_r;
  logic [stip_pkg::CHAR_BITS-1:0]   char_r;
  logic                             last_r;
  logic                             in_valid_r;
  logic                             out_valid_r;
  stip_pkg::result_t                res_r;
  stip_pkg::parse_state_t           st_r;
  stip_pkg::parse_state_t           st_nxt;
  stip_pkg::result_t                res_nxt;
  logic                             adv;
  logic                             proc;

  assign adv       = !out_valid_r || out_tready;
  assign proc      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  stip_step u_step (
    .radix     (radix_r),
    .char_code (char_r),
    .last_char (last_r),
    .cur       (st_r),
    .nxt       (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= stip_pkg::RADIX_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= stip_pkg::STATE_CLEAR;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (proc) begin
        st_r <= st_nxt;
      end
      if (adv) begin
        out_valid_r <= proc && last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (proc && last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = stip_pkg::OUT_DATA_BITS'(res_r);

endmodule
`default_nettype wire

// ----- design/stip_checker.sv -----
// Port-level checker for the parser, bound to the top level.
`default_nettype none
module stip_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [stip_pkg::OUT_DATA_BITS-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[81:80] == stip_pkg::ST_BASE ||
                   out_tdata[81:80] == stip_pkg::ST_CHAR)
      |-> out_tdata[63:0] == '1)
    else $error("bad base or character without all-ones value");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[87:82] == '0)
    else $error("result padding not zero");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind string_to_integer_parser_unit stip_checker u_stip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
